// ----- rtl/rras_pkg.sv -----
// Shared types and constants for the rectangle add/set/query grid block.
package rras_pkg;

    localparam int MAX_ROWS   = 16;
    localparam int MAX_COLS   = 256;
    localparam int ROW_W      = $clog2(MAX_ROWS);
    localparam int COL_W      = $clog2(MAX_COLS);
    localparam int CELLS      = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W     = ROW_W + COL_W;
    localparam int CELL_W     = 32;
    localparam int SUM_W      = 48;
    localparam int ROWS_REG_W = 5;
    localparam int COLS_REG_W = 9;
    localparam int CFG_W      = 9;
    localparam int IDX_W      = 1;

    localparam logic [IDX_W-1:0] REG_ROWS = 1'b0;
    localparam logic [IDX_W-1:0] REG_COLS = 1'b1;

    localparam logic [1:0] OP_ADD    = 2'd0;
    localparam logic [1:0] OP_SET    = 2'd1;
    localparam logic [1:0] OP_QUERY  = 2'd2;
    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef enum logic [5:0] {
        ST_IDLE  = 6'b000001,
        ST_CLEAR = 6'b000010,
        ST_SCAN  = 6'b000100,
        ST_DEC   = 6'b001000,
        ST_WRITE = 6'b010000,
        ST_OUT   = 6'b100000
    } state_t;

endpackage

// ----- rtl/rras_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module rras_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

// ----- rtl/rect_range_add_set_sum_min_max.sv -----
// Top level of the rectangle add/set/query grid block.
// Cells live in one RAM of MAX_ROWS*MAX_COLS 32-bit words, one read and one write per cycle.
// Each request scans its clipped rectangle cell by cell: a query or a set takes one pass, an
// add takes two (a maximum scan for the overflow check, then the update pass), or only the
// first pass when it overflows; an empty query skips the scan but still gives a result,
// and an empty add or set, or op 3, is dropped without a scan.
// The scan rate is set by the single RAM port. Writing either size register starts a clearing
// pass that zeroes every cell, during which no request is accepted; the clearing pass
// also runs after reset. The result waits in an output register until taken.
module rect_range_add_set_sum_min_max (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [rras_pkg::IDX_W-1:0]    cfg_index,
    input  logic [rras_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // op[1:0], row_first[5:2], col_first[13:6], row_last[17:14], col_last[25:18],
    // value[57:26], zero fill [63:58]
    input  logic [63:0]                   s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // range_sum[47:0], range_min[79:48], range_max[111:80], overflow[112], zero fill [119:113]
    output logic [119:0]                  m_tdata
);
    import rras_pkg::*;

    state_t state_reg, state_next;
    logic [ROWS_REG_W-1:0] rows_reg;
    logic [COLS_REG_W-1:0] cols_reg;
    logic                  ovf_reg;
    logic                  clr_pend_reg;
    logic [1:0]            op_reg;
    logic [ROW_W-1:0]      r0_reg, r1_reg, r_reg, wr_r_reg;
    logic [COL_W-1:0]      c0_reg, c1_reg, c_reg, wr_c_reg;
    logic [CELL_W-1:0]     val_reg;
    logic                  pass2_reg;   // add: update pass after maximum scan
    logic                  rd_v_reg;    // a read issued last cycle
    logic                  rd_last_reg;
    logic [SUM_W-1:0]      sum_reg;
    logic [CELL_W-1:0]     mn_reg, mx_reg;
    logic [ADDR_W-1:0]     clr_addr_reg;
    logic                  out_v_reg;
    logic [112:0]          out_reg;

    logic                  ram_we;
    logic [ADDR_W-1:0]     ram_waddr, ram_raddr;
    logic [CELL_W-1:0]     ram_wdata, ram_rdata;

    logic [ROW_W-1:0]      in_r0, in_r1, r1_clip, last_row;
    logic [COL_W-1:0]      in_c0, in_c1, c1_clip, last_col;
    logic                  in_empty, scan_last;
    logic [CELL_W:0]       add_chk;

    rras_ram #(.WIDTH(CELL_W), .DEPTH(CELLS)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    assign in_r0    = s_tdata[5:2];
    assign in_c0    = s_tdata[13:6];
    assign in_r1    = s_tdata[17:14];
    assign in_c1    = s_tdata[25:18];
    assign last_row = ROW_W'(rows_reg - 5'd1);
    assign last_col = COL_W'(cols_reg - 9'd1);
    assign r1_clip  = (in_r1 > last_row) ? last_row : in_r1;
    assign c1_clip  = (in_c1 > last_col) ? last_col : in_c1;
    assign in_empty = (in_r0 > r1_clip) || (in_c0 > c1_clip);
    assign scan_last = (r_reg == r1_reg) && (c_reg == c1_reg);
    assign add_chk  = {1'b0, mx_reg} + {1'b0, val_reg};

    assign s_tready = (state_reg == ST_IDLE) && !out_v_reg && !clr_pend_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {7'd0, out_reg};

    assign ram_raddr = {r_reg, c_reg};

    // Read data arrives in the cycle after the address; sets and add updates write the cell then.
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = {wr_r_reg, wr_c_reg};
        ram_wdata = ram_rdata + val_reg;
        if (state_reg == ST_CLEAR)
        begin
            ram_we    = 1'b1;
            ram_waddr = clr_addr_reg;
            ram_wdata = '0;
        end
        else if (rd_v_reg && op_reg == OP_SET)
        begin
            ram_we    = 1'b1;
            ram_wdata = val_reg;
        end
        else if (rd_v_reg && op_reg == OP_ADD && pass2_reg)
        begin
            ram_we = 1'b1;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clr_pend_reg)
                    state_next = ST_CLEAR;
                else if (s_tvalid && s_tready)
                begin
                    if (s_tdata[1:0] == OP_QUERY && in_empty)
                        state_next = ST_OUT;
                    else if (s_tdata[1:0] != OP_UNUSED && !in_empty)
                        state_next = ST_SCAN;
                end
            end
            ST_CLEAR: if (clr_addr_reg == ADDR_W'(CELLS - 1)) state_next = ST_IDLE;
            ST_SCAN:  if (scan_last) state_next = ST_DEC;
            ST_DEC:   state_next = ST_WRITE;
            ST_WRITE:
            begin
                if (op_reg == OP_QUERY)
                    state_next = ST_OUT;
                else if (op_reg == OP_ADD && !pass2_reg && add_chk[CELL_W] == 1'b0)
                    state_next = ST_SCAN;
                else
                    state_next = ST_IDLE;
            end
            ST_OUT:   state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            rows_reg     <= 5'd1;
            cols_reg     <= 9'd1;
            ovf_reg      <= 1'b0;
            clr_pend_reg <= 1'b1;
            clr_addr_reg <= '0;
            out_v_reg    <= 1'b0;
            rd_v_reg     <= 1'b0;
            rd_last_reg  <= 1'b0;
            pass2_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            rd_v_reg  <= (state_reg == ST_SCAN);
            rd_last_reg <= (state_reg == ST_SCAN) && scan_last;
            if (m_tvalid && m_tready)
                out_v_reg <= 1'b0;
            if (cfg_we)
            begin
                if (cfg_index == REG_ROWS)
                begin
                    rows_reg <= (cfg_data[4:0] == 5'd0) ? 5'd1 :
                                (cfg_data[4:0] > 5'(MAX_ROWS)) ? 5'(MAX_ROWS) : cfg_data[4:0];
                end
                else
                begin
                    cols_reg <= (cfg_data == 9'd0) ? 9'd1 :
                                (cfg_data > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cfg_data;
                end
                ovf_reg      <= 1'b0;
                clr_pend_reg <= 1'b1;
            end
            else if (state_reg == ST_IDLE && clr_pend_reg)
            begin
                clr_pend_reg <= 1'b0;
            end
            if (state_reg == ST_IDLE)
                clr_addr_reg <= '0;
            else if (state_reg == ST_CLEAR)
                clr_addr_reg <= clr_addr_reg + 1'b1;
            if (state_reg == ST_IDLE && s_tvalid && s_tready)
                pass2_reg <= 1'b0;
            if (state_reg == ST_WRITE)
            begin
                if (op_reg == OP_ADD && !pass2_reg)
                begin
                    if (add_chk[CELL_W])
                        ovf_reg <= 1'b1;
                    pass2_reg <= 1'b1;
                end
            end
            if (state_reg == ST_OUT)
                out_v_reg <= 1'b1;
        end
    end

    // Datapath: scan counters, accumulators, result register.
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_IDLE && s_tvalid && s_tready)
        begin
            op_reg  <= s_tdata[1:0];
            r0_reg  <= in_r0;
            c0_reg  <= in_c0;
            r1_reg  <= r1_clip;
            c1_reg  <= c1_clip;
            r_reg   <= in_r0;
            c_reg   <= in_c0;
            val_reg <= s_tdata[57:26];
            sum_reg <= '0;
            mn_reg  <= '1;
            mx_reg  <= '0;
            out_reg <= {ovf_reg, 112'd0};
        end
        else if (state_reg == ST_SCAN)
        begin
            wr_r_reg <= r_reg;
            wr_c_reg <= c_reg;
            if (c_reg == c1_reg)
            begin
                c_reg <= c0_reg;
                r_reg <= r_reg + 1'b1;
            end
            else
            begin
                c_reg <= c_reg + 1'b1;
            end
        end
        else if (state_reg == ST_WRITE)
        begin
            r_reg <= r0_reg;
            c_reg <= c0_reg;
            out_reg <= {ovf_reg, mx_reg, mn_reg, sum_reg};
        end
        if (rd_v_reg)
        begin
            sum_reg <= sum_reg + SUM_W'(ram_rdata);
            if (ram_rdata < mn_reg) mn_reg <= ram_rdata;
            if (ram_rdata > mx_reg) mx_reg <= ram_rdata;
        end
    end

    // A result never appears while a request is being processed.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> !out_v_reg)
        else $error("result pending during scan");
    // No request is taken during a clearing pass.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !s_tready)
        else $error("ready during clear");
    // The last read of a scan is followed by the decision step.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_last_reg |-> (state_reg == ST_WRITE || $past(state_reg) == ST_DEC
                         || state_reg == ST_DEC))
        else $error("scan end out of order");
endmodule

// ----- tb/sv/testbench.sv -----
// Testbench for the rectangle add/set/query grid block: directed and random requests checked
// against a cell-array predictor.
`timescale 1ns / 100ps

module testbench;
    import rras_pkg::*;

    localparam int WATCHDOG_LIMIT = 200000;
    // An add with no result may still be scanning the whole grid when the last result arrives.
    localparam int SETTLE_CYCLES  = 8400;

    typedef struct packed {
        logic [SUM_W-1:0]  sum;
        logic [CELL_W-1:0] min;
        logic [CELL_W-1:0] max;
        logic              ovf;
    } grid_answer_t;

    logic               clk;
    logic               rst_n;
    logic               cfg_we;
    logic [IDX_W-1:0]   cfg_index;
    logic [CFG_W-1:0]   cfg_data;
    logic               s_tvalid;
    logic               s_tready;
    logic [63:0]        s_tdata;
    logic               m_tvalid;
    logic               m_tready;
    logic [119:0]       m_tdata;

    // Predictor state.
    logic [CELL_W-1:0]  grid_cells [MAX_ROWS][MAX_COLS];
    logic               grid_ovf;
    int unsigned        grid_rows;
    int unsigned        grid_cols;

    grid_answer_t       answers_q [$];
    int                 errors;
    int                 send_idle_pct;
    int                 recv_idle_pct;
    int                 hold_cycles;
    int                 quiet_cycles;
    int                 requests_sent;
    int                 answers_checked;

    rect_range_add_set_sum_min_max i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    initial clk = 1'b0;
    always #6 clk = ~clk;

    function automatic void clear_grid();
        for (int r = 0; r < MAX_ROWS; r++)
        begin
            for (int c = 0; c < MAX_COLS; c++)
            begin
                grid_cells[r][c] = '0;
            end
        end
        grid_ovf = 1'b0;
    endfunction

    // Applies one request to the predicted grid; returns 1 when a query answer is produced.
    function automatic bit predict_request(input logic [1:0] op, input logic [3:0] r0,
                                           input logic [7:0] c0, input logic [3:0] r1,
                                           input logic [7:0] c1, input logic [31:0] v,
                                           output grid_answer_t ans);
        int unsigned       rl;
        int unsigned       cl;
        bit                empty;
        logic [SUM_W-1:0]  sum;
        logic [CELL_W-1:0] mn;
        logic [CELL_W-1:0] mx;
        sum = '0;
        mn  = '1;
        mx  = '0;
        ans = '0;
        if (op != OP_ADD && op != OP_SET && op != OP_QUERY)
            return 0;
        rl = (r1 > grid_rows - 1) ? grid_rows - 1 : r1;
        cl = (c1 > grid_cols - 1) ? grid_cols - 1 : c1;
        empty = (r0 > rl) || (c0 > cl);
        if (!empty)
        begin
            for (int r = r0; r <= rl; r++)
            begin
                for (int c = c0; c <= cl; c++)
                begin
                    sum += grid_cells[r][c];
                    if (grid_cells[r][c] < mn) mn = grid_cells[r][c];
                    if (grid_cells[r][c] > mx) mx = grid_cells[r][c];
                end
            end
        end
        if (op == OP_QUERY)
        begin
            if (empty)
            begin
                sum = '0;
                mn  = '0;
                mx  = '0;
            end
            ans.sum = sum;
            ans.min = mn;
            ans.max = mx;
            ans.ovf = grid_ovf;
            return 1;
        end
        if (empty)
            return 0;
        if (op == OP_ADD && ({1'b0, mx} + {1'b0, v}) > 33'hFFFF_FFFF)
        begin
            // The whole add is dropped when any cell would wrap.
            grid_ovf = 1'b1;
            return 0;
        end
        for (int r = r0; r <= rl; r++)
        begin
            for (int c = c0; c <= cl; c++)
            begin
                grid_cells[r][c] = (op == OP_ADD) ? grid_cells[r][c] + v : v;
            end
        end
        return 0;
    endfunction

    task automatic send_request(input logic [1:0] op, input logic [3:0] r0, input logic [7:0] c0,
                                input logic [3:0] r1, input logic [7:0] c1, input logic [31:0] v);
        grid_answer_t ans;
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {6'b0, v, c1, r1, c0, r0, op};
        if (predict_request(op, r0, c0, r1, c1, v, ans))
            answers_q.push_back(ans);
        requests_sent++;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (answers_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_size(input logic [IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        int unsigned v;
        wait_idle();
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_we    <= 1'b0;
        if (idx == REG_ROWS)
        begin
            v = data[ROWS_REG_W-1:0];
            grid_rows = (v == 0) ? 1 : (v > MAX_ROWS) ? MAX_ROWS : v;
        end
        else
        begin
            v = data[COLS_REG_W-1:0];
            grid_cols = (v == 0) ? 1 : (v > MAX_COLS) ? MAX_COLS : v;
        end
        clear_grid();
    endtask

    function automatic logic [31:0] pick_value();
        case ($urandom_range(3))
            0: return $urandom_range(255);
            1: return $urandom;
            2: return 32'hFFFF_FFFF - $urandom_range(3);
            default: return $urandom_range(7) == 0 ? 32'h0 : $urandom_range(15);
        endcase
    endfunction

    task automatic send_random_request();
        logic [1:0]  op;
        logic [3:0]  r0;
        logic [3:0]  r1;
        logic [7:0]  c0;
        logic [7:0]  c1;
        int unsigned pick;
        int unsigned cmax;
        pick = $urandom_range(99);
        op = (pick < 38) ? OP_ADD : (pick < 62) ? OP_SET : (pick < 96) ? OP_QUERY : OP_UNUSED;
        if ($urandom_range(99) < 82)
        begin
            // Well-formed rectangle inside the grid, kept narrow so scans stay short.
            r0 = 4'($urandom_range(grid_rows - 1));
            r1 = 4'($urandom_range(r0, grid_rows - 1));
            c0 = 8'($urandom_range(grid_cols - 1));
            cmax = (c0 + 15 < grid_cols - 1) ? c0 + 15 : grid_cols - 1;
            c1 = 8'($urandom_range(c0, cmax));
        end
        else
        begin
            r0 = 4'($urandom);
            r1 = 4'($urandom);
            c0 = 8'($urandom);
            c1 = 8'($urandom);
        end
        send_request(op, r0, c0, r1, c1, pick_value());
    endtask

    task automatic test_directed();
        // Fresh after reset: 1x1 grid.
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd15, 8'd255, 32'd0);
        send_request(OP_ADD, 4'd0, 8'd0, 4'd0, 8'd0, 32'hFFFF_FFFF);
        send_request(OP_ADD, 4'd0, 8'd0, 4'd0, 8'd0, 32'd1);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd0, 8'd0, 32'd0);
        write_size(REG_ROWS, 9'd4);
        write_size(REG_COLS, 9'd8);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd3, 8'd7, 32'd0);
        send_request(OP_SET, 4'd1, 8'd2, 4'd2, 8'd5, 32'd100);
        send_request(OP_ADD, 4'd0, 8'd0, 4'd15, 8'd255, 32'd7);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd3, 8'd7, 32'd0);
        // A set to zero must stick.
        send_request(OP_SET, 4'd2, 8'd3, 4'd3, 8'd7, 32'd0);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd3, 8'd7, 32'd0);
        send_request(OP_ADD, 4'd2, 8'd0, 4'd2, 8'd7, 32'hFFFF_FFF0);
        send_request(OP_QUERY, 4'd2, 8'd0, 4'd2, 8'd7, 32'd0);
        // Empty rectangles: first past last, and first beyond the grid after clipping.
        send_request(OP_SET, 4'd3, 8'd5, 4'd1, 8'd6, 32'd9);
        send_request(OP_QUERY, 4'd3, 8'd5, 4'd1, 8'd6, 32'd0);
        send_request(OP_QUERY, 4'd15, 8'd255, 4'd15, 8'd255, 32'd0);
        send_request(OP_ADD, 4'd0, 8'd9, 4'd3, 8'd200, 32'd5);
        send_request(OP_UNUSED, 4'd0, 8'd0, 4'd3, 8'd7, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd3, 8'd7, 32'd0);
    endtask

    task automatic test_full_grid();
        // Sizes above the maximum act as the maximum.
        write_size(REG_ROWS, 9'd31);
        write_size(REG_COLS, 9'd511);
        send_request(OP_SET, 4'd0, 8'd0, 4'd15, 8'd255, 32'hFFFF_FFFF);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd15, 8'd255, 32'd0);
        send_request(OP_SET, 4'd15, 8'd250, 4'd15, 8'd255, 32'd3);
        send_request(OP_ADD, 4'd15, 8'd250, 4'd15, 8'd255, 32'd4);
        send_request(OP_QUERY, 4'd15, 8'd248, 4'd15, 8'd255, 32'd0);
        send_request(OP_ADD, 4'd0, 8'd0, 4'd0, 8'd3, 32'd1);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd0, 8'd3, 32'd0);
        // Size zero acts as one.
        write_size(REG_ROWS, 9'd0);
        write_size(REG_COLS, 9'd0);
        send_request(OP_ADD, 4'd0, 8'd0, 4'd9, 8'd77, 32'd12);
        send_request(OP_QUERY, 4'd0, 8'd0, 4'd15, 8'd255, 32'd0);
    endtask

    task automatic test_random(input int count);
        int unsigned rows_pick [6] = '{5, 16, 2, 9, 1, 3};
        int unsigned cols_pick [6] = '{17, 12, 256, 6, 40, 1};
        for (int p = 0; p < 6; p++)
        begin
            write_size(REG_ROWS, CFG_W'(rows_pick[p]));
            write_size(REG_COLS, CFG_W'(cols_pick[p]));
            for (int i = 0; i < count / 6; i++)
                send_random_request();
        end
    endtask

    task automatic test_backpressure();
        write_size(REG_ROWS, 9'd2);
        write_size(REG_COLS, 9'd3);
        hold_cycles = 900;
        for (int i = 0; i < 12; i++)
            send_request(OP_QUERY, 4'd0, 8'($urandom_range(2)), 4'd1, 8'd2, 32'd0);
        for (int i = 0; i < 12; i++)
            send_random_request();
    endtask

    // Result checker, receiver stalls and watchdog.
    always @(posedge clk)
    begin
        grid_answer_t want;
        grid_answer_t got;
        if (rst_n)
        begin
            if ((m_tvalid && m_tready) || (s_tvalid && s_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no request moved for %0d cycles", $time, quiet_cycles);
                $display("Mismatches found");
                $finish;
            end
            if (m_tvalid && m_tready)
            begin
                got.sum = m_tdata[47:0];
                got.min = m_tdata[79:48];
                got.max = m_tdata[111:80];
                got.ovf = m_tdata[112];
                if (answers_q.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, actual %h", $time, got);
                end
                else
                begin
                    want = answers_q.pop_front();
                    answers_checked++;
                    if (got.sum !== want.sum)
                        $display("%0t: range_sum expected %h actual %h", $time, want.sum, got.sum);
                    if (got.min !== want.min)
                        $display("%0t: range_min expected %h actual %h", $time, want.min, got.min);
                    if (got.max !== want.max)
                        $display("%0t: range_max expected %h actual %h", $time, want.max, got.max);
                    if (got.ovf !== want.ovf)
                        $display("%0t: overflow expected %b actual %b", $time, want.ovf, got.ovf);
                    if (got !== want)
                        errors++;
                end
            end
        end
        if (hold_cycles > 0)
        begin
            hold_cycles--;
            m_tready <= 1'b0;
        end
        else
            m_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    initial
    begin
        errors          = 0;
        hold_cycles     = 0;
        quiet_cycles    = 0;
        requests_sent   = 0;
        answers_checked = 0;
        send_idle_pct   = 29;
        recv_idle_pct   = 46;
        grid_rows       = 1;
        grid_cols       = 1;
        clear_grid();
        rst_n     <= 1'b0;
        cfg_we    <= 1'b0;
        cfg_index <= '0;
        cfg_data  <= '0;
        s_tvalid  <= 1'b0;
        s_tdata   <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_full_grid();
        test_random(250);
        send_idle_pct = 46;
        recv_idle_pct = 29;
        test_random(250);
        test_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random(250);
        wait_idle();

        $display("Sent %0d requests over grids from 1x1 to 16x256, checked %0d query results.",
                 requests_sent, answers_checked);
        $display("Covered clipping, empty rectangles, set to zero, add overflow and back-pressure.");
        if (errors == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
